// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker of the kernel evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define VKE_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define VKE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define VKE_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/vke_pkg.sv =====
// ----------------------------------------------------------------------------
// vke_pkg
// Codes and constants of the vector kernel evaluator.
// ----------------------------------------------------------------------------
package vke_pkg;

   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BANDWIDTH   = 1'b1;

   localparam logic [3:0] MODE_L1        = 4'd0;
   localparam logic [3:0] MODE_SQDIST    = 4'd1;
   localparam logic [3:0] MODE_UNIT_GAUSS = 4'd2;
   localparam logic [3:0] MODE_GAUSS     = 4'd3;
   localparam logic [3:0] MODE_LAPLACE   = 4'd4;
   localparam logic [3:0] MODE_INVMQ     = 4'd5;
   localparam logic [3:0] MODE_RATIONAL  = 4'd6;
   localparam logic [3:0] MODE_WDIST     = 4'd7;
   localparam logic [3:0] MODE_ANIGAUSS  = 4'd8;

   // ln(2) in Q2.30.
   localparam logic [63:0] LN2_Q30      = 64'd744261118;
   localparam int          EXP_Q        = 30;
   localparam logic [3:0]  TAYLOR_TERMS = 4'd10;
   localparam logic [47:0] OUT_MAX      = 48'hFFFF_FFFF_FFFF;

endpackage

// ===== rtl/vector_kernel_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// vector_kernel_evaluator_core
// Distance and radial-basis kernel evaluator in fixed point.
// ----------------------------------------------------------------------------
// Usage: each req_ beat carries one coordinate pair, a per-dimension width and
// a last flag. The term for the current kernel mode is added to a saturating
// 64-bit accumulator. The beat marked last produces one rsp_ beat with the
// kernel value and a saturation flag, after which the accumulator clears.
// The user must write registers through csr_ only while the block is idle;
// the block itself does not enforce this. One shared restoring divider and
// one shared multiplier do all the work under a sequencer. A weighted beat
// takes one division. On a last beat the result adds one division for modes
// 3, 4 and 6, a square root plus a division for mode 5, and for the
// exponential modes a six-step range reduction and ten series terms, each
// through the states S_TMUL, S_TDIV, S_TFIX and S_TACC. req_stall is high
// while a beat is at work. A finished result sits in an output register;
// the block accepts the next beat while it waits and only holds a later
// result until the receiver takes it. Reset restores mode 3 and bandwidth
// 1.0, clears the accumulator and empties the output register.
// ----------------------------------------------------------------------------
module vector_kernel_evaluator_core
   import vke_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_x_coord,
   input  logic signed [31:0]   req_y_coord,
   input  logic [31:0]          req_dim_width,
   input  logic                 req_last_dim,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [47:0]          rsp_kernel_value,
   output logic                 rsp_saturated,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wr_data
);

   localparam int DIVW   = 64 + FRAC_BITS;
   localparam int CNTW   = $clog2(DIVW + 1);
   localparam int NB     = 64 + FRAC_BITS + (FRAC_BITS % 2);
   localparam int SQN    = NB / 2;
   localparam int REMW   = SQN + 2;
   localparam int SQCW   = $clog2(SQN + 1);
   localparam int EXP_SH = EXP_Q - FRAC_BITS;
   localparam int KBITS  = 6;
   localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;
   localparam logic [63:0] TCAP = 64'd32 << FRAC_BITS;
   localparam logic [63:0] RECIP_NUM = (64'd1 << 33) - 64'd1;

   typedef enum logic [4:0] {
      S_IDLE, S_ITEM, S_WQ, S_SQ, S_ACC, S_FIN, S_DIV, S_TCAP, S_RAT, S_SQRT,
      S_IMQ, S_EXP0, S_EXP1, S_TMUL, S_TDIV, S_TFIX, S_TACC, S_SHIFT, S_OUT
   } state_type;

   state_type          state_ff, ret_ff;
   logic [3:0]         mode_ff;
   logic [31:0]        bw_ff;
   logic [63:0]        acc_ff;
   logic               ovf_ff;
   logic               clip_ff;
   logic [32:0]        ad_ff;
   logic [31:0]        w_ff;
   logic               last_ff;
   logic [63:0]        add_term_ff;
   logic [65:0]        prod_ff;
   logic [DIVW-1:0]    div_quo_ff;
   logic [63:0]        div_rem_ff;
   logic [63:0]        div_den_ff;
   logic [CNTW-1:0]    div_cnt_ff;
   logic [NB-1:0]      rad_ff;
   logic [SQN-1:0]     root_ff;
   logic [REMW-1:0]    srem_ff;
   logic [SQCW-1:0]    sq_cnt_ff;
   logic [63:0]        texp_ff;
   logic [6:0]         k_ff;
   logic [29:0]        r_ff;
   logic [30:0]        term_ff;
   logic [30:0]        tx_ff;
   logic signed [33:0] sum_ff;
   logic [3:0]         n_ff;
   logic [63:0]        v_ff;
   logic               rsp_valid_ff;
   logic [47:0]        rsp_value_ff;
   logic               rsp_sat_ff;

   logic [32:0]        mul_a, mul_b;
   logic [32:0]        diff;
   logic [64:0]        rem2, div_sub;
   logic               div_ge;
   logic [63:0]        div_rem_in;
   logic [REMW-1:0]    srem2, cand;
   logic               sq_ge;
   logic [64:0]        acc_sum;
   logic [63:0]        h2;
   logic [64:0]        h2_acc;
   logic [63:0]        quo_cap;
   logic [63:0]        sum_pos;
   logic [7:0]         sh;
   logic [63:0]        exp_big;
   logic [32:0]        recip;
   logic [30:0]        q_est;
   logic [34:0]        qn;
   logic [34:0]        trem;
   logic [30:0]        tq;

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kernel_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;

   // Reciprocals floor((2^33-1)/n) of the series divisors. The scaled product
   // is at most one below the true quotient, so one correction step is enough.
   always_comb begin
      case (n_ff)
         4'd1:    recip = 33'(RECIP_NUM);
         4'd2:    recip = 33'(RECIP_NUM / 64'd2);
         4'd3:    recip = 33'(RECIP_NUM / 64'd3);
         4'd4:    recip = 33'(RECIP_NUM / 64'd4);
         4'd5:    recip = 33'(RECIP_NUM / 64'd5);
         4'd6:    recip = 33'(RECIP_NUM / 64'd6);
         4'd7:    recip = 33'(RECIP_NUM / 64'd7);
         4'd8:    recip = 33'(RECIP_NUM / 64'd8);
         4'd9:    recip = 33'(RECIP_NUM / 64'd9);
         4'd10:   recip = 33'(RECIP_NUM / 64'd10);
         default: recip = 33'(RECIP_NUM);
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_ITEM: begin
            mul_a = ad_ff;
            mul_b = ad_ff;
         end
         S_WQ: begin
            mul_a = {1'b0, div_quo_ff[31:0]};
            mul_b = {1'b0, div_quo_ff[31:0]};
         end
         S_ACC: begin
            mul_a = {1'b0, bw_ff};
            mul_b = {1'b0, bw_ff};
         end
         S_TMUL: begin
            mul_a = {2'b0, term_ff};
            mul_b = {3'b0, r_ff};
         end
         S_TDIV: begin
            mul_a = {2'b0, prod_ff[EXP_Q +: 31]};
            mul_b = recip;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      diff       = {req_x_coord[31], req_x_coord} - {req_y_coord[31], req_y_coord};
      // One restoring division step.
      rem2       = {div_rem_ff, div_quo_ff[DIVW-1]};
      div_sub    = rem2 - {1'b0, div_den_ff};
      div_ge     = (rem2 >= {1'b0, div_den_ff});
      div_rem_in = div_ge ? div_sub[63:0] : rem2[63:0];
      // One digit of the square root.
      srem2      = {srem_ff[REMW-3:0], rad_ff[NB-1:NB-2]};
      cand       = {root_ff, 2'b01};
      sq_ge      = (srem2 >= cand);
      acc_sum    = {1'b0, acc_ff} + {1'b0, add_term_ff};
      h2         = 64'(prod_ff >> FRAC_BITS);
      h2_acc     = {1'b0, h2} + {1'b0, acc_ff};
      quo_cap    = (div_quo_ff >= DIVW'(TCAP)) ? TCAP : div_quo_ff[63:0];
      sum_pos    = sum_ff[33] ? 64'd0 : 64'(sum_ff);
      sh         = 8'(k_ff) + 8'(EXP_SH);
      exp_big    = texp_ff << EXP_SH;
      // Series term: scaled product, then at most one correction by n.
      q_est      = prod_ff[63:33];
      qn         = {4'b0, q_est} * {31'b0, n_ff};
      trem       = {4'b0, tx_ff} - qn;
      tq         = (trem >= {31'b0, n_ff}) ? (q_est + 31'd1) : q_est;
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         mode_ff      <= MODE_GAUSS;
         bw_ff        <= 32'(ONE);
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_KERNEL_MODE: mode_ff <= csr_wr_data[3:0];
               CSR_BANDWIDTH:   bw_ff   <= csr_wr_data;
               default:         ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  ad_ff    <= diff[32] ? (33'd0 - diff) : diff;
                  w_ff     <= req_dim_width;
                  last_ff  <= req_last_dim;
                  state_ff <= S_ITEM;
               end
            end
            S_ITEM: begin
               if (mode_ff inside {MODE_L1, MODE_LAPLACE}) begin
                  add_term_ff <= 64'(ad_ff);
                  state_ff    <= S_ACC;
               end else if (mode_ff inside {MODE_WDIST, MODE_ANIGAUSS}) begin
                  div_quo_ff <= DIVW'(ad_ff) << FRAC_BITS;
                  div_rem_ff <= '0;
                  div_den_ff <= (w_ff == 32'd0) ? 64'd1 : 64'(w_ff);
                  div_cnt_ff <= CNTW'(DIVW);
                  ret_ff     <= S_WQ;
                  state_ff   <= S_DIV;
               end else begin
                  state_ff <= S_SQ;
               end
            end
            S_WQ: begin
               if (|div_quo_ff[DIVW-1:32]) begin
                  add_term_ff <= '1;
                  ovf_ff      <= 1'b1;
                  state_ff    <= S_ACC;
               end else begin
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               add_term_ff <= 64'(prod_ff >> FRAC_BITS);
               state_ff    <= S_ACC;
            end
            S_ACC: begin
               if (acc_sum[64]) begin
                  acc_ff <= '1;
                  ovf_ff <= 1'b1;
               end else begin
                  acc_ff <= acc_sum[63:0];
               end
               clip_ff  <= 1'b0;
               state_ff <= last_ff ? S_FIN : S_IDLE;
            end
            S_FIN: begin
               div_rem_ff <= '0;
               div_cnt_ff <= CNTW'(DIVW);
               case (mode_ff)
                  MODE_UNIT_GAUSS, MODE_ANIGAUSS: begin
                     texp_ff  <= acc_ff >> 1;
                     state_ff <= S_EXP0;
                  end
                  MODE_GAUSS: begin
                     div_quo_ff <= DIVW'(acc_ff) << FRAC_BITS;
                     div_den_ff <= (h2 == 64'd0) ? 64'd1 : {h2[62:0], 1'b0};
                     ret_ff     <= S_TCAP;
                     state_ff   <= S_DIV;
                  end
                  MODE_LAPLACE: begin
                     div_quo_ff <= DIVW'(acc_ff) << FRAC_BITS;
                     div_den_ff <= (bw_ff == 32'd0) ? 64'd1 : 64'(bw_ff);
                     ret_ff     <= S_TCAP;
                     state_ff   <= S_DIV;
                  end
                  MODE_INVMQ: begin
                     clip_ff <= h2_acc[64];
                     if (h2_acc[64]) begin
                        rad_ff <= NB'({64'hFFFF_FFFF_FFFF_FFFF, FRAC_BITS'(0)});
                     end else begin
                        rad_ff <= NB'({h2_acc[63:0], FRAC_BITS'(0)});
                     end
                     srem_ff   <= '0;
                     root_ff   <= '0;
                     sq_cnt_ff <= SQCW'(SQN);
                     // A zero sum has a zero root, which reads as infinity.
                     if (h2_acc == 65'd0) begin
                        v_ff     <= '1;
                        state_ff <= S_OUT;
                     end else begin
                        state_ff <= S_SQRT;
                     end
                  end
                  MODE_RATIONAL: begin
                     clip_ff    <= h2_acc[64];
                     div_quo_ff <= DIVW'(acc_ff) << FRAC_BITS;
                     div_den_ff <= h2_acc[64] ? '1 : h2_acc[63:0];
                     if (h2_acc == 65'd0) begin
                        v_ff     <= ONE;
                        state_ff <= S_OUT;
                     end else begin
                        ret_ff   <= S_RAT;
                        state_ff <= S_DIV;
                     end
                  end
                  default: begin
                     v_ff     <= acc_ff;
                     state_ff <= S_OUT;
                  end
               endcase
            end
            S_DIV: begin
               div_rem_ff <= div_rem_in;
               div_quo_ff <= {div_quo_ff[DIVW-2:0], div_ge};
               div_cnt_ff <= div_cnt_ff - 1'b1;
               if (div_cnt_ff == CNTW'(1)) begin
                  state_ff <= ret_ff;
               end
            end
            S_TCAP: begin
               texp_ff  <= quo_cap;
               state_ff <= S_EXP0;
            end
            S_RAT: begin
               v_ff     <= ONE - quo_cap;
               state_ff <= S_OUT;
            end
            S_SQRT: begin
               srem_ff   <= sq_ge ? (srem2 - cand) : srem2;
               root_ff   <= {root_ff[SQN-2:0], sq_ge};
               rad_ff    <= rad_ff << 2;
               sq_cnt_ff <= sq_cnt_ff - 1'b1;
               if (sq_cnt_ff == SQCW'(1)) begin
                  state_ff <= S_IMQ;
               end
            end
            S_IMQ: begin
               // First pass: start 2^(2F) / root. Second pass: take quotient.
               if (ret_ff == S_IMQ) begin
                  v_ff     <= div_quo_ff[63:0];
                  ret_ff   <= S_IDLE;
                  state_ff <= S_OUT;
               end else begin
                  div_quo_ff <= DIVW'(1) << (2 * FRAC_BITS);
                  div_rem_ff <= '0;
                  div_den_ff <= 64'(root_ff);
                  div_cnt_ff <= CNTW'(DIVW);
                  ret_ff     <= S_IMQ;
                  state_ff   <= S_DIV;
               end
            end
            S_EXP0: begin
               if (texp_ff >= TCAP) begin
                  v_ff     <= '0;
                  state_ff <= S_OUT;
               end else begin
                  // Range reduction: t = k*ln2 + r. The scaled t is below
                  // 2^35, so its upper bits already sit below ln2 and six
                  // compare-and-subtract steps give k.
                  div_quo_ff <= {exp_big[KBITS-1:0], {(DIVW-KBITS){1'b0}}};
                  div_rem_ff <= exp_big >> KBITS;
                  div_den_ff <= LN2_Q30;
                  div_cnt_ff <= CNTW'(KBITS);
                  ret_ff     <= S_EXP1;
                  state_ff   <= S_DIV;
               end
            end
            S_EXP1: begin
               k_ff     <= div_quo_ff[6:0];
               r_ff     <= div_rem_ff[29:0];
               term_ff  <= 31'd1 << EXP_Q;
               sum_ff   <= 34'sd1 <<< EXP_Q;
               n_ff     <= 4'd1;
               state_ff <= S_TMUL;
            end
            S_TMUL: begin
               state_ff <= S_TDIV;
            end
            S_TDIV: begin
               tx_ff    <= prod_ff[EXP_Q +: 31];
               state_ff <= S_TFIX;
            end
            S_TFIX: begin
               term_ff  <= tq;
               state_ff <= S_TACC;
            end
            S_TACC: begin
               if (n_ff[0]) begin
                  sum_ff <= sum_ff - $signed({3'b0, term_ff});
               end else begin
                  sum_ff <= sum_ff + $signed({3'b0, term_ff});
               end
               if (n_ff == TAYLOR_TERMS) begin
                  state_ff <= S_SHIFT;
               end else begin
                  n_ff     <= n_ff + 1'b1;
                  state_ff <= S_TMUL;
               end
            end
            S_SHIFT: begin
               if (sh > 8'd62) begin
                  v_ff <= '0;
               end else begin
                  v_ff <= (sum_pos + (64'd1 << (sh - 8'd1))) >> sh;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  if (v_ff > 64'(OUT_MAX)) begin
                     rsp_value_ff <= OUT_MAX;
                     rsp_sat_ff   <= 1'b1;
                  end else begin
                     rsp_value_ff <= v_ff[47:0];
                     rsp_sat_ff   <= ovf_ff | clip_ff;
                  end
                  acc_ff   <= '0;
                  ovf_ff   <= 1'b0;
                  ret_ff   <= S_IDLE;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/vke_checker.sv =====
// ----------------------------------------------------------------------------
// vke_checker
// Port-level checks of the kernel evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vke_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [47:0] rsp_kernel_value,
   input logic        rsp_saturated
);

   // A result beat that is held back keeps its value.
   `VKE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_kernel_value) && $stable(rsp_saturated))

   // An accepted beat keeps the block busy in the following cycle.
   `VKE_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // A new result only appears right after the sequencer was busy.
   `VKE_ASSERT_IMPL(a_rsp_from_work, $rose(rsp_valid), $past(req_stall))

   // Reset empties the output register.
   `VKE_ASSERT_NEXT_ALWAYS(a_reset_clears, reset, !rsp_valid && !req_stall)

endmodule

bind vector_kernel_evaluator_core vke_checker u_vke_checker (.*);
